// ----- src/two_digit_reciprocal_assert.svh -----
// Assertion macros used by the checker file.
`ifndef TWO_DIGIT_RECIPROCAL_ASSERT_SVH
`define TWO_DIGIT_RECIPROCAL_ASSERT_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define TDR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Assert that an antecedent implies a consequent in the next cycle.
`define TDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- src/tdr_pkg.sv -----
`default_nettype none
package tdr_pkg;
    localparam int DIGIT_BITS_DEFAULT = 64;
    localparam int FIELD_BITS = 64;
    // Number of quotient bits resolved in each pipeline stage
    localparam int BITS_PER_STAGE_DEFAULT = 4;
endpackage
`default_nettype wire

// ----- src/two_digit_reciprocal.sv -----
// Two-digit reciprocal: for a normalized divisor d = {divisor_high, divisor_low} in base
// B = 2^DIGIT_BITS, returns floor(B^3/(d+1)) - B; an all-ones divisor gives 0, and a divisor
// with the top digit bit clear gives 0 with not_normalized set. Bits of the inputs at and
// above DIGIT_BITS are ignored. The block takes one transaction per cycle unless the
// output holds. One input stage forms d+1 and the starting remainder, then a chain of
// restoring-division stages each resolves up to BITS_PER_STAGE quotient bits. The whole
// pipeline stalls together when the output holds.
`default_nettype none
module two_digit_reciprocal
    import tdr_pkg::*;
#(
    parameter int DIGIT_BITS = DIGIT_BITS_DEFAULT,
    parameter int BITS_PER_STAGE = BITS_PER_STAGE_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [FIELD_BITS-1:0] divisor_high,
    input  wire logic [FIELD_BITS-1:0] divisor_low,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [FIELD_BITS-1:0]      reciprocal,
    output logic                       not_normalized
);
    localparam int NSTAGE = (DIGIT_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int W2 = 2 * DIGIT_BITS;

    logic advance;
    logic [NSTAGE:0]          v;
    logic [W2-1:0]            rem [NSTAGE+1];
    logic [W2-1:0]            dv  [NSTAGE+1];
    logic [DIGIT_BITS-1:0]    quo [NSTAGE+1];
    logic [NSTAGE:0]          flg;

    // Stall every stage together while the result waits
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    // Input stage: form d+1, starting remainder and special-case flags
    logic                  v0_reg;
    logic [W2-1:0]         rem0_reg, dv0_reg;
    logic                  nn0_reg, zero0_reg;
    logic [DIGIT_BITS-1:0] d1, d0;
    assign d1 = divisor_high[DIGIT_BITS-1:0];
    assign d0 = divisor_low[DIGIT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (advance)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem0_reg  <= ~{d1, d0};
            dv0_reg   <= {d1, d0} + W2'(1);
            nn0_reg   <= !d1[DIGIT_BITS-1];
            zero0_reg <= !d1[DIGIT_BITS-1] || (&{d1, d0});
        end
    end

    assign v[0]   = v0_reg;
    assign rem[0] = rem0_reg;
    assign dv[0]  = dv0_reg;
    assign quo[0] = '0;
    assign flg[0] = zero0_reg;

    // Carry the normalization flag alongside the zero flag
    logic [NSTAGE:0] nnp;
    assign nnp[0] = nn0_reg;

    for (genvar s = 0; s < NSTAGE; s++)
    begin : g_stage
        localparam int STEPS = ((s + 1) * BITS_PER_STAGE > DIGIT_BITS) ?
                               (DIGIT_BITS - s * BITS_PER_STAGE) : BITS_PER_STAGE;
        logic nn_reg;
        tdr_stage #(.DIGIT_BITS(DIGIT_BITS), .STEPS(STEPS)) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .in_valid (v[s]),
            .in_rem   (rem[s]),
            .in_div   (dv[s]),
            .in_quo   (quo[s]),
            .in_flag  (flg[s]),
            .out_valid(v[s+1]),
            .out_rem  (rem[s+1]),
            .out_div  (dv[s+1]),
            .out_quo  (quo[s+1]),
            .out_flag (flg[s+1])
        );
        always_ff @(posedge clk)
        begin
            if (advance)
                nn_reg <= nnp[s];
        end
        assign nnp[s+1] = nn_reg;
    end

    // Drive the result; special cases give zero
    assign out_valid      = v[NSTAGE];
    assign reciprocal     = flg[NSTAGE] ? '0 : FIELD_BITS'(quo[NSTAGE]);
    assign not_normalized = nnp[NSTAGE];
endmodule
`default_nettype wire

// ----- src/tdr_stage.sv -----
`default_nettype none
module tdr_stage
    import tdr_pkg::*;
#(
    parameter int DIGIT_BITS = DIGIT_BITS_DEFAULT,
    parameter int STEPS = BITS_PER_STAGE_DEFAULT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    advance,
    input  wire logic                    in_valid,
    input  wire logic [2*DIGIT_BITS-1:0] in_rem,
    input  wire logic [2*DIGIT_BITS-1:0] in_div,
    input  wire logic [DIGIT_BITS-1:0]   in_quo,
    input  wire logic                    in_flag,
    output logic                         out_valid,
    output logic [2*DIGIT_BITS-1:0]      out_rem,
    output logic [2*DIGIT_BITS-1:0]      out_div,
    output logic [DIGIT_BITS-1:0]        out_quo,
    output logic                         out_flag
);
    logic                    valid_reg;
    logic [2*DIGIT_BITS-1:0] rem_reg, rem_next;
    logic [2*DIGIT_BITS-1:0] div_reg;
    logic [DIGIT_BITS-1:0]   quo_reg, quo_next;
    logic                    flag_reg;

    // Run STEPS restoring division steps on the shifted remainder
    always_comb
    begin
        logic [2*DIGIT_BITS:0] sh;
        logic [2*DIGIT_BITS:0] diff;
        rem_next = in_rem;
        quo_next = in_quo;
        for (int i = 0; i < STEPS; i++)
        begin
            sh = {rem_next, 1'b0};
            diff = sh - {1'b0, in_div};
            if (!diff[2*DIGIT_BITS])
            begin
                rem_next = diff[2*DIGIT_BITS-1:0];
                quo_next = {quo_next[DIGIT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = sh[2*DIGIT_BITS-1:0];
                quo_next = {quo_next[DIGIT_BITS-2:0], 1'b0};
            end
        end
    end

    // Hold valid under reset, advance when the pipeline moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg  <= rem_next;
            div_reg  <= in_div;
            quo_reg  <= quo_next;
            flag_reg <= in_flag;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_quo   = quo_reg;
    assign out_flag  = flag_reg;
endmodule
`default_nettype wire

// ----- src/tdr_checker.sv -----
`default_nettype none
`include "two_digit_reciprocal_assert.svh"
module tdr_checker
    import tdr_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [FIELD_BITS-1:0] reciprocal,
    input wire logic                  not_normalized
);
    // An unnormalized divisor always reports zero
    `TDR_ASSERT_IMPL(a_nn_zero, clk, rst_n, out_valid && not_normalized, reciprocal == '0)
    // A waiting result holds
    `TDR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(reciprocal) && $stable(not_normalized))
    // Input is open whenever the output is free
    `TDR_ASSERT_IMPL(a_ready, clk, rst_n, !out_valid || out_ready, in_ready)
    // A waiting input transaction stays offered
    `TDR_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)
endmodule
bind two_digit_reciprocal tdr_checker u_tdr_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .reciprocal(reciprocal), .not_normalized(not_normalized)
);
`default_nettype wire

// ----- test/two_digit_reciprocal_test.sv -----
module two_digit_reciprocal_test;
    import tdr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGIT_BITS = DIGIT_BITS_DEFAULT;
    localparam int LATENCY = 1 + DIGIT_BITS / BITS_PER_STAGE_DEFAULT;
    localparam logic [FIELD_BITS-1:0] ALL_ONES = {FIELD_BITS{1'b1}};
    localparam logic [FIELD_BITS-1:0] TOP_BIT = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [FIELD_BITS-1:0] recip;
        logic                  unnorm;
    } recip_result_t;

    // Compute floor(B^3/(d+1)) - B as a quotient of (B^2-(d+1))*B by d+1.
    function automatic recip_result_t reciprocal_of(logic [FIELD_BITS-1:0] hi,
                                                    logic [FIELD_BITS-1:0] lo);
        recip_result_t res;
        logic [2*DIGIT_BITS:0]   denom;
        logic [3*DIGIT_BITS-1:0] numer;
        logic [3*DIGIT_BITS-1:0] quot;
        logic [DIGIT_BITS-1:0]   d1;
        logic [DIGIT_BITS-1:0]   d0;
        d1 = hi[DIGIT_BITS-1:0];
        d0 = lo[DIGIT_BITS-1:0];
        res = '0;
        if (!d1[DIGIT_BITS-1])
        begin
            res.unnorm = 1'b1;
            return res;
        end
        denom = {1'b0, d1, d0} + 1'b1;
        numer = {~d1, ~d0, {DIGIT_BITS{1'b0}}};
        quot = numer / denom;
        res.recip = FIELD_BITS'(quot[DIGIT_BITS-1:0]);
        return res;
    endfunction

    class recip_scoreboard;
        recip_result_t pending[$];
        int errors = 0;

        function void note_divisor(logic [FIELD_BITS-1:0] hi, logic [FIELD_BITS-1:0] lo);
            pending.push_back(reciprocal_of(hi, lo));
        endfunction

        function void check_result(logic [FIELD_BITS-1:0] recip, logic unnorm);
            recip_result_t exp_res;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected transaction recip=%h unnorm=%b", $realtime, recip, unnorm);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (recip !== exp_res.recip)
            begin
                $display("%0t: reciprocal expected %h actual %h", $realtime, exp_res.recip, recip);
                errors++;
            end
            if (unnorm !== exp_res.unnorm)
            begin
                $display("%0t: not_normalized expected %b actual %b", $realtime,
                         exp_res.unnorm, unnorm);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [FIELD_BITS-1:0] divisor_high = '0;
    logic [FIELD_BITS-1:0] divisor_low = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [FIELD_BITS-1:0] reciprocal;
    logic not_normalized;

    recip_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;

    two_digit_reciprocal i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .divisor_high(divisor_high),
        .divisor_low(divisor_low),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .reciprocal(reciprocal),
        .not_normalized(not_normalized)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Note each input transaction and check each output transaction.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_divisor(divisor_high, divisor_low);
        if (rst_n && out_valid && out_ready)
            board.check_result(reciprocal, not_normalized);
    end

    // Drive out_ready: a long hold-off when asked, random stalls otherwise.
    initial
    begin
        @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_off_cycles--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one divisor, with a random idle gap first, and hold until accepted.
    task automatic send_divisor(logic [FIELD_BITS-1:0] hi, logic [FIELD_BITS-1:0] lo);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        divisor_high <= hi;
        divisor_low <= lo;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid, let the last transaction be noted, then wait for every result.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // Mostly normalized divisors, with edge-heavy digits now and then.
    function automatic logic [FIELD_BITS-1:0] random_digit();
        case ($urandom_range(7))
            0: return ALL_ONES;
            1: return '0;
            2: return ALL_ONES - $urandom_range(3);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_random(int count);
        logic [FIELD_BITS-1:0] hi;
        repeat (count)
        begin
            hi = random_digit();
            if ($urandom_range(9) != 0)
                hi = hi | TOP_BIT;
            send_divisor(hi, random_digit());
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes and special cases.
        send_divisor(ALL_ONES, ALL_ONES);
        send_divisor(TOP_BIT, '0);
        send_divisor(TOP_BIT, ALL_ONES);
        send_divisor(ALL_ONES, '0);
        send_divisor(ALL_ONES, ALL_ONES - 1);
        send_divisor(ALL_ONES - 1, ALL_ONES);
        send_divisor(64'hC000_0000_0000_0000, ALL_ONES);
        send_divisor(TOP_BIT - 1, ALL_ONES);
        send_divisor('0, '0);
        send_divisor('0, ALL_ONES);
        send_divisor(64'h7FFF_FFFF_FFFF_FFFF, '0);
        send_divisor(TOP_BIT | 64'h1, 64'h1);
        send_divisor(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_divisor(64'hD555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        drain_results();

        // Random phases with different idling mixes.
        send_random(110);
        send_idle_pct = 47;
        send_random(80);
        // Pause the sender until every expected transaction has come back.
        drain_results();
        send_idle_pct = 0;
        recv_stall_pct = 47;
        send_random(80);
        // Hold off the receiver long enough to back up the pipeline.
        hold_off_cycles = 3 * LATENCY + 20;
        send_random(60);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        send_random(80);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(30);

        drain_results();
        repeat (LATENCY + 5) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
